@@ hw/rtl/tlpw_pkg.sv @@
// Shared types and constants for the two-level page walker.
package tlpw_pkg;

  localparam int MEM_WORDS_DEF = 65536;
  localparam int FRAME_W       = 20;
  localparam int OFS_BITS      = 12;
  localparam int IDX_W         = 10;
  localparam int WORD_ADDR_W   = FRAME_W + IDX_W;
  localparam int DATA_W        = 32;
  localparam int WIDX_W        = 16;
  localparam int FAULT_W       = 2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_XLATE = 1'b1;

  localparam logic [FAULT_W-1:0] FAULT_NONE  = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_DIR   = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_TBL   = 2'd2;
  localparam logic [FAULT_W-1:0] FAULT_RANGE = 2'd3;

  typedef struct packed {
    logic accept;
    logic tbl_issue;
    logic in_tbl;
    logic load_out;
    logic src_pend;
    logic save;
  } cmd_t;

  typedef struct packed {
    logic xlate;
    logic dir_end;
  } status_t;

endpackage

@@ hw/rtl/tlpw_ctrl.sv @@
// Walk sequencer: input/output handshake and walk step control.
module tlpw_ctrl
  import tlpw_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIR  = 4'b0010,
    S_TBL  = 4'b0100,
    S_HOLD = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (st.xlate) state_nxt = S_DIR;
        end
      end
      S_DIR: begin
        if (st.dir_end) begin
          if (out_free) begin
            cmd.load_out = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            cmd.save  = 1'b1;
            state_nxt = S_HOLD;
          end
        end else begin
          cmd.tbl_issue = 1'b1;
          state_nxt     = S_TBL;
        end
      end
      S_TBL: begin
        cmd.in_tbl = 1'b1;
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.save  = 1'b1;
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          cmd.src_pend = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hw/rtl/tlpw_datapath.sv @@
// Walk datapath: memory store, entry address forming, fault checks, result registers.
module tlpw_datapath
  import tlpw_pkg::*;
#(
  parameter int MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [FRAME_W-1:0] cfg_wr_data,
  input  logic               in_opcode,
  input  logic [DATA_W-1:0]  in_linear_addr,
  input  logic [WIDX_W-1:0]  in_word_index,
  input  logic [DATA_W-1:0]  in_word_data,
  input  cmd_t               cmd,
  output status_t            st,
  output logic [DATA_W-1:0]  out_phys_addr,
  output logic [FAULT_W-1:0] out_fault
);

  localparam int AW = $clog2(MEM_WORDS);
  localparam logic [WORD_ADDR_W-1:0] MEM_LIMIT = WORD_ADDR_W'(MEM_WORDS);

  logic [DATA_W-1:0]      mem [MEM_WORDS];
  logic [FRAME_W-1:0]     dir_frame_r;
  logic [DATA_W-1:0]      la_r;
  logic                   dir_oob_r;
  logic                   tbl_oob_r;
  logic [DATA_W-1:0]      rd_data_r;
  logic [DATA_W-1:0]      pend_phys_r;
  logic [FAULT_W-1:0]     pend_fault_r;
  logic [DATA_W-1:0]      out_phys_r;
  logic [FAULT_W-1:0]     out_fault_r;

  logic [WORD_ADDR_W-1:0] dir_word;
  logic [WORD_ADDR_W-1:0] tbl_word;
  logic [WORD_ADDR_W-1:0] wr_word;
  logic                   wr_en;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [DATA_W-1:0]      live_phys;
  logic [FAULT_W-1:0]     live_fault;

  assign dir_word = {dir_frame_r, in_linear_addr[31:22]};
  assign tbl_word = {rd_data_r[31:12], la_r[21:12]};
  assign wr_word  = WORD_ADDR_W'(in_word_index);
  assign wr_en    = cmd.accept && (in_opcode == OP_WRITE) && (wr_word < MEM_LIMIT);
  assign rd_en    = (cmd.accept && (in_opcode == OP_XLATE)) || cmd.tbl_issue;
  assign rd_addr  = cmd.accept ? dir_word[AW-1:0] : tbl_word[AW-1:0];

  assign st.xlate   = (in_opcode == OP_XLATE);
  assign st.dir_end = dir_oob_r || !rd_data_r[0];

  always_comb begin
    live_phys = '0;
    if (cmd.in_tbl) begin
      priority if (tbl_oob_r) begin
        live_fault = FAULT_RANGE;
      end else if (!rd_data_r[0]) begin
        live_fault = FAULT_TBL;
      end else begin
        live_fault = FAULT_NONE;
        live_phys  = {rd_data_r[31:12], la_r[OFS_BITS-1:0]};
      end
    end else begin
      live_fault = dir_oob_r ? FAULT_RANGE : FAULT_DIR;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_word[AW-1:0]] <= in_word_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_frame_r <= '0;
    end else if (cfg_wr_en) begin
      dir_frame_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      la_r      <= in_linear_addr;
      dir_oob_r <= (dir_word >= MEM_LIMIT);
    end
    if (cmd.tbl_issue) begin
      tbl_oob_r <= (tbl_word >= MEM_LIMIT);
    end
    if (cmd.save) begin
      pend_phys_r  <= live_phys;
      pend_fault_r <= live_fault;
    end
    if (cmd.load_out) begin
      out_phys_r  <= cmd.src_pend ? pend_phys_r : live_phys;
      out_fault_r <= cmd.src_pend ? pend_fault_r : live_fault;
    end
  end

  assign out_phys_addr = out_phys_r;
  assign out_fault     = out_fault_r;

endmodule

@@ hw/rtl/two_level_page_walker.sv @@
// Two-level page walker top level: sequencer plus walk datapath.
// Walk: a translation reads its directory entry, then its table entry, skipping the table read
// when the directory entry faults or lies out of range; a write returns nothing.
// Throughput: a translation must finish before the next request is taken, as its two dependent
// reads share the single memory read port; one write per cycle while no walk runs.
// Reset: rst_n (synchronous, active low) clears control and dir_frame, not the memory.
module two_level_page_walker
  import tlpw_pkg::*;
#(
  parameter int MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [FRAME_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic [DATA_W-1:0]  in_linear_addr,
  input  logic [WIDX_W-1:0]  in_word_index,
  input  logic [DATA_W-1:0]  in_word_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DATA_W-1:0]  out_phys_addr,
  output logic [FAULT_W-1:0] out_fault
);

  cmd_t    cmd;
  status_t st;

  tlpw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  tlpw_datapath #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_opcode      (in_opcode),
    .in_linear_addr (in_linear_addr),
    .in_word_index  (in_word_index),
    .in_word_data   (in_word_data),
    .cmd            (cmd),
    .st             (st),
    .out_phys_addr  (out_phys_addr),
    .out_fault      (out_fault)
  );

endmodule

@@ hw/rtl/tlpw_checker.sv @@
// Port-level checks for the two-level page walker, bound to the top level.
module tlpw_checker
  import tlpw_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               cfg_wr_en,
  input logic [FRAME_W-1:0] cfg_wr_data,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_opcode,
  input logic [DATA_W-1:0]  in_linear_addr,
  input logic [WIDX_W-1:0]  in_word_index,
  input logic [DATA_W-1:0]  in_word_data,
  input logic               out_valid,
  input logic               out_ready,
  input logic [DATA_W-1:0]  out_phys_addr,
  input logic [FAULT_W-1:0] out_fault
);

  a_fault_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fault != FAULT_NONE) |-> (out_phys_addr == '0))
    else $error("faulted transfer carries a nonzero address");

  a_xlate_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_opcode == OP_XLATE) |=> !in_ready)
    else $error("ready during a walk");

  a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_opcode == OP_WRITE) |=> in_ready)
    else $error("ready dropped after a memory write");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_phys_addr) && $stable(out_fault)))
    else $error("stalled result changed");

endmodule

bind two_level_page_walker tlpw_checker u_tlpw_checker (.*);

@@ sim/two_level_page_walker_check.sv @@
`timescale 1ns / 100ps
// Checker for the two-level page walker: predicts each translation and compares results.
module two_level_page_walker_check
  import tlpw_pkg::*;
#(
  parameter int MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [FRAME_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_opcode,
  input  logic [DATA_W-1:0]  in_linear_addr,
  input  logic [WIDX_W-1:0]  in_word_index,
  input  logic [DATA_W-1:0]  in_word_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [DATA_W-1:0]  out_phys_addr,
  input  logic [FAULT_W-1:0] out_fault,
  output int                 pending,
  output int                 errors
);

  typedef struct packed {
    logic [DATA_W-1:0]  linear_addr;
    logic [DATA_W-1:0]  phys_addr;
    logic [FAULT_W-1:0] fault;
  } xlate_t;

  logic [DATA_W-1:0]  mem_image [MEM_WORDS];
  logic [FRAME_W-1:0] dir_frame;
  xlate_t             xlate_q [$];

  function automatic xlate_t walk_pages(input logic [DATA_W-1:0] la);
    xlate_t            res;
    logic [DATA_W-1:0] word;
    logic [DATA_W-1:0] pde;
    logic [DATA_W-1:0] pte;
    res.linear_addr = la;
    res.phys_addr   = '0;
    res.fault       = FAULT_NONE;
    word = {2'b00, dir_frame, la[31:22]};
    if (word >= MEM_WORDS) begin
      res.fault = FAULT_RANGE;
      return res;
    end
    pde = mem_image[word];
    if (!pde[0]) begin
      res.fault = FAULT_DIR;
      return res;
    end
    word = {2'b00, pde[31:12], la[21:12]};
    if (word >= MEM_WORDS) begin
      res.fault = FAULT_RANGE;
      return res;
    end
    pte = mem_image[word];
    if (!pte[0]) begin
      res.fault = FAULT_TBL;
      return res;
    end
    res.phys_addr = {pte[31:12], la[11:0]};
    return res;
  endfunction

  task automatic log_mismatch(input string msg);
    if (errors < 10) $display("%0t ns: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    xlate_t want;
    if (!rst_n) begin
      dir_frame = '0;
      xlate_q.delete();
      errors = 0;
    end else begin
      if (cfg_wr_en) dir_frame = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (xlate_q.size() == 0) begin
          log_mismatch($sformatf("result with none pending: phys_addr %h fault %0d",
                                 out_phys_addr, out_fault));
        end else begin
          want = xlate_q.pop_front();
          if (out_phys_addr !== want.phys_addr)
            log_mismatch($sformatf("phys_addr for linear %h: expected %h, got %h",
                                   want.linear_addr, want.phys_addr, out_phys_addr));
          if (out_fault !== want.fault)
            log_mismatch($sformatf("fault for linear %h: expected %0d, got %0d",
                                   want.linear_addr, want.fault, out_fault));
        end
      end
      if (in_valid && in_ready) begin
        if (in_opcode == OP_WRITE) begin
          if (in_word_index < MEM_WORDS) mem_image[in_word_index] = in_word_data;
        end else begin
          xlate_q.push_back(walk_pages(in_linear_addr));
        end
      end
    end
    pending = xlate_q.size();
  end

endmodule

@@ sim/two_level_page_walker_test.sv @@
`timescale 1ns / 100ps
// Testbench top for the two-level page walker: stimulus, handshake pacing and verdict.
module two_level_page_walker_test
  import tlpw_pkg::*;
();

  localparam int MEM_WORDS     = MEM_WORDS_DEF;
  localparam int FRAMES_IN_MEM = MEM_WORDS >> IDX_W;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               cfg_wr_en      = 1'b0;
  logic [FRAME_W-1:0] cfg_wr_data    = '0;
  logic               in_valid       = 1'b0;
  logic               in_ready;
  logic               in_opcode      = OP_WRITE;
  logic [DATA_W-1:0]  in_linear_addr = '0;
  logic [WIDX_W-1:0]  in_word_index  = '0;
  logic [DATA_W-1:0]  in_word_data   = '0;
  logic               out_valid;
  logic               out_ready      = 1'b0;
  logic [DATA_W-1:0]  out_phys_addr;
  logic [FAULT_W-1:0] out_fault;
  int                 pending;
  int                 errors;

  logic [DATA_W-1:0]  shadow_mem [MEM_WORDS];
  bit                 shadow_written [MEM_WORDS];
  logic [FRAME_W-1:0] cur_dir_frame = '0;
  int                 items_sent = 0;
  bit                 tx_calm = 1'b0;
  bit                 rx_calm = 1'b0;
  int                 rx_hold = 0;
  int                 rx_count = 0;

  two_level_page_walker #(.MEM_WORDS(MEM_WORDS)) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_linear_addr (in_linear_addr),
    .in_word_index  (in_word_index),
    .in_word_data   (in_word_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_phys_addr  (out_phys_addr),
    .out_fault      (out_fault)
  );

  two_level_page_walker_check #(.MEM_WORDS(MEM_WORDS)) u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_linear_addr (in_linear_addr),
    .in_word_index  (in_word_index),
    .in_word_data   (in_word_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_phys_addr  (out_phys_addr),
    .out_fault      (out_fault),
    .pending        (pending),
    .errors         (errors)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int draw_wait(input bit calm);
    if (calm || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      rx_count++;
      if (rx_count % 50 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      rx_hold = draw_wait(rx_calm);
    end else if (rx_hold > 0) begin
      rx_hold--;
    end
    out_ready <= rst_n && (rx_hold == 0);
  end

  function automatic bit word_safe(input logic [DATA_W-1:0] word);
    if (word >= MEM_WORDS) return 1'b1;
    return shadow_written[word];
  endfunction

  // a walk is safe when it never reads a word that was not written
  function automatic bit walk_safe(input logic [DATA_W-1:0] la);
    logic [DATA_W-1:0] word;
    logic [DATA_W-1:0] pde;
    word = {2'b00, cur_dir_frame, la[31:22]};
    if (word >= MEM_WORDS) return 1'b1;
    if (!shadow_written[word]) return 1'b0;
    pde = shadow_mem[word];
    if (!pde[0]) return 1'b1;
    return word_safe({2'b00, pde[31:12], la[21:12]});
  endfunction

  task automatic send_item(input logic op, input logic [DATA_W-1:0] la,
                           input logic [WIDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    int gap;
    if (items_sent % 64 == 0) tx_calm = ($urandom_range(0, 3) == 0);
    gap = draw_wait(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_linear_addr <= la;
    in_word_index  <= idx;
    in_word_data   <= data;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic store_word(input logic [WIDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    shadow_mem[idx]     = data;
    shadow_written[idx] = 1'b1;
    send_item(OP_WRITE, $urandom, idx, data);
  endtask

  task automatic translate(input logic [DATA_W-1:0] la);
    send_item(OP_XLATE, la, 16'($urandom), $urandom);
  endtask

  task automatic drain_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_dir_frame(input logic [FRAME_W-1:0] frame);
    drain_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= frame;
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    cur_dir_frame  = frame;
  endtask

  // build a directory entry, a table entry if it is valid and in range, then walk them
  task automatic run_walk_scenario();
    logic [IDX_W-1:0]   d;
    logic [IDX_W-1:0]   t;
    logic [FRAME_W-1:0] frame;
    logic [DATA_W-1:0]  pde;
    logic [DATA_W-1:0]  pte;
    logic [DATA_W-1:0]  la;
    logic [DATA_W-1:0]  try_la;
    logic [DATA_W-1:0]  word;
    int                 n;
    d = 10'($urandom);
    t = 10'($urandom);
    if ($urandom_range(0, 3) != 0) frame = 20'($urandom_range(0, FRAMES_IN_MEM - 1));
    else frame = 20'($urandom);
    if (frame == cur_dir_frame && t == d) t = d + 10'd1;
    pde    = {frame, 12'($urandom)};
    pde[0] = ($urandom_range(0, 7) != 0);
    word   = {2'b00, cur_dir_frame, d};
    store_word(word[WIDX_W-1:0], pde);
    word = {2'b00, frame, t};
    if (pde[0] && word < MEM_WORDS) begin
      pte    = $urandom;
      pte[0] = ($urandom_range(0, 7) != 0);
      store_word(word[WIDX_W-1:0], pte);
    end
    n = $urandom_range(1, 4);
    repeat (n) begin
      la = {d, t, 12'($urandom)};
      case ($urandom_range(0, 4))
        0: begin
          try_la = {d, 10'($urandom), 12'($urandom)};
        end
        1: begin
          try_la = $urandom;
        end
        default: begin
          try_la = la;
        end
      endcase
      translate(walk_safe(try_la) ? try_la : la);
    end
    if ($urandom_range(0, 3) == 0) store_word(16'($urandom), $urandom);
  endtask

  initial begin
    logic [FRAME_W-1:0] setting;
    int                 budget;
    int                 start;
    int                 waited;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    store_word(16'd0, 32'h0000_1001);
    store_word(16'd1024, 32'hFFFF_F001);
    translate(32'h0000_0FFF);
    store_word(16'd2047, 32'h0000_0001);
    translate(32'h003F_F000);
    store_word(16'd1023, 32'h0000_0000);
    translate(32'hFFC0_0000);
    store_word(16'd1025, 32'hFFFF_FFFE);
    translate(32'h0000_1ABC);
    store_word(16'd1, 32'h0004_0001);
    translate(32'h0040_0000);
    store_word(16'd2, 32'hFFFF_F001);
    translate(32'h00BF_FFFF);
    store_word(16'd65535, 32'hFFFF_FFFF);
    set_dir_frame(FRAME_W'(FRAMES_IN_MEM - 1));
    translate(32'hFFFF_FFFF);
    store_word(16'd65535, 32'h0000_0003);
    translate(32'hFFFF_F5A5);
    translate(32'hFFC0_0ABC);
    set_dir_frame(FRAME_W'(FRAMES_IN_MEM));
    translate(32'h0000_0000);
    set_dir_frame('1);
    translate(32'hFFFF_FFFF);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          setting = '0;
        end
        1: begin
          setting = FRAME_W'(FRAMES_IN_MEM - 1);
        end
        2: begin
          setting = FRAME_W'(FRAMES_IN_MEM);
        end
        3: begin
          setting = '1;
        end
        default: begin
          setting = 20'($urandom_range(1, FRAMES_IN_MEM - 2));
        end
      endcase
      set_dir_frame(setting);
      budget = (setting >= FRAMES_IN_MEM) ? 40 : 160;
      start  = items_sent;
      while (items_sent - start < budget) begin
        if (setting >= FRAMES_IN_MEM) begin
          if ($urandom_range(0, 3) == 0) store_word(16'($urandom), $urandom);
          else translate($urandom);
        end else begin
          run_walk_scenario();
        end
        if ($urandom_range(0, 99) == 0) drain_idle();
      end
    end

    in_valid <= 1'b0;
    waited = 0;
    do begin
      @(negedge clk);
      waited++;
    end while (pending != 0 && waited < 20000);
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("two_level_page_walker_test: PASS");
    end else begin
      $display("two_level_page_walker_test: FAIL");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("two_level_page_walker_test: FAIL");
    $finish;
  end

endmodule
